FILE: rtl/core/bta_pkg.sv
// Shared types, constants and trit helpers for the balanced-ternary ALU.
package bta_pkg;

   // Default word geometry and fixed field widths.
   localparam int TRITS_DEF = 20;
   localparam int FRAC_DEF  = 8;
   localparam int WORD_W    = 40;
   localparam int INT_W     = 32;
   localparam int FUNC_W    = 3;

   // Two-bit trit codes; the spare code reads as zero.
   localparam logic [1:0] DIGIT_ZERO  = 2'b00;
   localparam logic [1:0] DIGIT_PLUS  = 2'b01;
   localparam logic [1:0] DIGIT_MINUS = 2'b10;

   // Operation selector.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD      = 3'd0,
      FUNC_SUB      = 3'd1,
      FUNC_NEG      = 3'd2,
      FUNC_MUL      = 3'd3,
      FUNC_FMUL     = 3'd4,
      FUNC_TO_INT   = 3'd5,
      FUNC_FROM_INT = 3'd6
   } func_type;

   // Sideband that travels with every pipeline stage.
   typedef struct packed {
      logic     valid;
      func_type func;
   } ctl_type;

   // Power of three, evaluated at elaboration.
   function automatic longint unsigned pow3(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 3;
      end
      return p;
   endfunction

   // Signed value of one trit code.
   function automatic logic signed [1:0] digit_value(input logic [1:0] code);
      logic signed [1:0] v;
      case (code)
         DIGIT_PLUS:  v = 2'sb01;
         DIGIT_MINUS: v = 2'sb11;
         default:     v = 2'sb00;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/bta_conv.sv
// Pipelined conversion of a balanced binary value into packed trits, top trit first.
module bta_conv #(
   parameter int TRITS = bta_pkg::TRITS_DEF,
   parameter int VW    = 36
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  bta_pkg::ctl_type                 in_ctl,
   input  logic signed [VW-1:0]             in_value,
   input  logic signed [bta_pkg::INT_W-1:0] in_int,
   output bta_pkg::ctl_type                 out_ctl,
   output logic [2*TRITS-1:0]               out_word,
   output logic signed [bta_pkg::INT_W-1:0] out_int
);

   localparam int TW = 2 * TRITS;

   bta_pkg::ctl_type                 ctl_ff  [TRITS];
   logic signed [VW-1:0]             val_ff  [TRITS];
   logic [TW-1:0]                    word_ff [TRITS];
   logic signed [bta_pkg::INT_W-1:0] int_ff  [TRITS];

   for (genvar s = 0; s < TRITS; s++) begin : g_stage
      localparam int K = TRITS - 1 - s;
      localparam logic signed [VW-1:0] POW_V  = VW'(bta_pkg::pow3(K));
      localparam logic signed [VW-1:0] HALF_V = VW'((bta_pkg::pow3(K) - 1) / 2);

      bta_pkg::ctl_type                 ctl_src;
      logic signed [VW-1:0]             val_src;
      logic [TW-1:0]                    word_src;
      logic signed [bta_pkg::INT_W-1:0] int_src;
      logic signed [VW-1:0]             val_in;
      logic [TW-1:0]                    word_in;

      if (s == 0) begin : g_first
         assign ctl_src  = in_ctl;
         assign val_src  = in_value;
         assign word_src = '0;
         assign int_src  = in_int;
      end else begin : g_next
         assign ctl_src  = ctl_ff[s-1];
         assign val_src  = val_ff[s-1];
         assign word_src = word_ff[s-1];
         assign int_src  = int_ff[s-1];
      end

      // Pick trit K greedily; the remainder always fits the lower trits.
      always_comb begin
         val_in  = val_src;
         word_in = word_src;
         if (val_src > HALF_V) begin
            val_in              = val_src - POW_V;
            word_in[2*K +: 2]   = bta_pkg::DIGIT_PLUS;
         end else if (val_src < -HALF_V) begin
            val_in              = val_src + POW_V;
            word_in[2*K +: 2]   = bta_pkg::DIGIT_MINUS;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[s] <= ctl_src;
         end
         if (adv) begin
            val_ff[s]  <= val_in;
            word_ff[s] <= word_in;
            int_ff[s]  <= int_src;
         end
      end
   end

   assign out_ctl  = ctl_ff[TRITS-1];
   assign out_word = word_ff[TRITS-1];
   assign out_int  = int_ff[TRITS-1];

endmodule

FILE: rtl/core/balanced_ternary_alu.sv
// Top level of the pipelined balanced-ternary ALU.
// The unit accepts one operation per cycle while no result beat is held and
// returns the results in order. Operand a and the integer are first turned
// into binary values by a Horner chain that takes one trit and one integer bit
// per stage; a second chain of TRITS stages forms the product modulo 3^TRITS
// (or the addend for add and subtract), one combine stage finishes add,
// subtract and negate, and a final chain of TRITS stages rewrites the value as
// canonical trits. When a result beat is held by the consumer, the whole
// pipeline holds with it.
module balanced_ternary_alu #(
   parameter int TRITS = bta_pkg::TRITS_DEF,
   parameter int FRAC  = bta_pkg::FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bta_pkg::FUNC_W-1:0]          req_func,
   input  logic [bta_pkg::WORD_W-1:0]          req_operand_a,
   input  logic [bta_pkg::WORD_W-1:0]          req_operand_b,
   input  logic signed [bta_pkg::INT_W-1:0]    req_int_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bta_pkg::WORD_W-1:0]          rsp_result_word,
   output logic signed [bta_pkg::INT_W-1:0]    rsp_int_result
);

   localparam int INT_W = bta_pkg::INT_W;
   localparam int WORD_W = bta_pkg::WORD_W;
   localparam int TW = 2 * TRITS;
   localparam int NB = (TRITS > INT_W) ? TRITS : INT_W;
   localparam longint unsigned MOD = bta_pkg::pow3(TRITS);
   localparam int VW = $clog2(MOD) + 3;
   localparam logic signed [VW-1:0] MOD_V  = VW'(MOD);
   localparam logic signed [VW-1:0] MOD2_V = VW'(2 * MOD);
   localparam logic signed [VW-1:0] HALF_V = VW'((MOD - 1) / 2);
   localparam logic signed [VW-1:0] HI2_V  = VW'(MOD + (MOD - 1) / 2);
   localparam logic signed [VW-1:0] ONE_V  = VW'(1);

   // Global advance: every stage moves when the output register can take a beat.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Entry values.
   bta_pkg::ctl_type entry_ctl;
   assign entry_ctl.valid = req_valid;
   assign entry_ctl.func  = bta_pkg::func_type'(req_func);

   // ---------------- Phase 1: operand a and the integer to binary ----------------
   bta_pkg::ctl_type      p1_ctl_ff [NB];
   logic [TW-1:0]         p1_b_ff   [NB];
   logic [TW-1:0]         p1_a_ff   [NB];
   logic [INT_W-1:0]      p1_int_ff [NB];
   logic signed [VW-1:0]  p1_va_ff  [NB];
   logic signed [VW-1:0]  p1_ni_ff  [NB];

   for (genvar s = 0; s < NB; s++) begin : g_p1
      localparam int J = NB - 1 - s;

      bta_pkg::ctl_type     ctl_src;
      logic [TW-1:0]        a_src;
      logic [TW-1:0]        b_src;
      logic [INT_W-1:0]     int_src;
      logic signed [VW-1:0] va_src;
      logic signed [VW-1:0] ni_src;
      logic signed [1:0]    tv;
      logic                 ib;
      logic signed [VW-1:0] va_in;
      logic signed [VW-1:0] ni_sum;
      logic signed [VW-1:0] ni_in;

      if (s == 0) begin : g_first
         assign ctl_src = entry_ctl;
         assign a_src   = TW'(req_operand_a);
         assign b_src   = TW'(req_operand_b);
         assign int_src = req_int_value;
         assign va_src  = '0;
         assign ni_src  = '0;
      end else begin : g_next
         assign ctl_src = p1_ctl_ff[s-1];
         assign a_src   = p1_a_ff[s-1];
         assign b_src   = p1_b_ff[s-1];
         assign int_src = p1_int_ff[s-1];
         assign va_src  = p1_va_ff[s-1];
         assign ni_src  = p1_ni_ff[s-1];
      end

      if (J < TRITS) begin : g_trit
         assign tv = bta_pkg::digit_value(a_src[2*J +: 2]);
      end else begin : g_notrit
         assign tv = '0;
      end

      if (J < INT_W) begin : g_bit
         assign ib = int_src[J];
      end else begin : g_nobit
         assign ib = 1'b0;
      end

      // Horner steps: a stays in range; the integer is folded modulo 3^TRITS.
      always_comb begin
         va_in = (va_src <<< 1) + va_src + VW'(tv);
         if (J == INT_W - 1) begin
            ni_sum = (ni_src <<< 1) - $signed({{(VW-1){1'b0}}, ib});
         end else begin
            ni_sum = (ni_src <<< 1) + $signed({{(VW-1){1'b0}}, ib});
         end
         if (ni_sum > HALF_V) begin
            ni_in = ni_sum - MOD_V;
         end else if (ni_sum < -HALF_V) begin
            ni_in = ni_sum + MOD_V;
         end else begin
            ni_in = ni_sum;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            p1_ctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            p1_ctl_ff[s] <= ctl_src;
         end
         if (adv) begin
            p1_a_ff[s]   <= a_src;
            p1_b_ff[s]   <= b_src;
            p1_int_ff[s] <= int_src;
            p1_va_ff[s]  <= va_in;
            p1_ni_ff[s]  <= ni_in;
         end
      end
   end

   // ---------------- Phase 2: Horner over the trits of b ----------------
   bta_pkg::ctl_type      p2_ctl_ff [TRITS];
   logic [TW-1:0]         p2_b_ff   [TRITS];
   logic signed [VW-1:0]  p2_va_ff  [TRITS];
   logic signed [VW-1:0]  p2_acc_ff [TRITS];
   logic signed [VW-1:0]  p2_ni_ff  [TRITS];

   for (genvar s = 0; s < TRITS; s++) begin : g_p2
      localparam int K = TRITS - 1 - s;

      bta_pkg::ctl_type     ctl_src;
      logic [TW-1:0]        b_src;
      logic signed [VW-1:0] va_src;
      logic signed [VW-1:0] acc_src;
      logic signed [VW-1:0] ni_src;
      logic signed [1:0]    tv;
      logic signed [VW-1:0] mult;
      logic signed [VW-1:0] term;
      logic signed [VW-1:0] sum;
      logic signed [VW-1:0] acc_in;

      if (s == 0) begin : g_first
         assign ctl_src = p1_ctl_ff[NB-1];
         assign b_src   = p1_b_ff[NB-1];
         assign va_src  = p1_va_ff[NB-1];
         assign acc_src = '0;
         assign ni_src  = p1_ni_ff[NB-1];
      end else begin : g_next
         assign ctl_src = p2_ctl_ff[s-1];
         assign b_src   = p2_b_ff[s-1];
         assign va_src  = p2_va_ff[s-1];
         assign acc_src = p2_acc_ff[s-1];
         assign ni_src  = p2_ni_ff[s-1];
      end

      assign tv = bta_pkg::digit_value(b_src[2*K +: 2]);

      // Multiplicand per operation: a for products, plus or minus one for add and subtract.
      always_comb begin
         case (ctl_src.func) inside
            bta_pkg::FUNC_MUL, bta_pkg::FUNC_FMUL: mult = va_src;
            bta_pkg::FUNC_ADD:                     mult = ONE_V;
            bta_pkg::FUNC_SUB:                     mult = -ONE_V;
            default:                               mult = '0;
         endcase
      end

      // acc = 3*acc + trit*mult, brought back into the balanced range.
      always_comb begin
         if (tv == 2'sb01) begin
            term = mult;
         end else if (tv == 2'sb11) begin
            term = -mult;
         end else begin
            term = '0;
         end
         sum = (acc_src <<< 1) + acc_src + term;
         if (sum > HI2_V) begin
            acc_in = sum - MOD2_V;
         end else if (sum > HALF_V) begin
            acc_in = sum - MOD_V;
         end else if (sum < -HI2_V) begin
            acc_in = sum + MOD2_V;
         end else if (sum < -HALF_V) begin
            acc_in = sum + MOD_V;
         end else begin
            acc_in = sum;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            p2_ctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            p2_ctl_ff[s] <= ctl_src;
         end
         if (adv) begin
            p2_b_ff[s]   <= b_src;
            p2_va_ff[s]  <= va_src;
            p2_acc_ff[s] <= acc_in;
            p2_ni_ff[s]  <= ni_src;
         end
      end
   end

   // ---------------- Combine stage ----------------
   bta_pkg::ctl_type             cm_ctl_ff;
   logic signed [VW-1:0]         cm_val_ff;
   logic signed [INT_W-1:0]      cm_int_ff;
   logic signed [VW-1:0]         cm_val_in;
   logic signed [INT_W-1:0]      cm_int_in;
   logic signed [VW-1:0]         cm_sum;
   bta_pkg::ctl_type             cm_ctl_src;
   logic signed [VW-1:0]         cm_va;
   logic signed [VW-1:0]         cm_acc;

   assign cm_ctl_src = p2_ctl_ff[TRITS-1];
   assign cm_va      = p2_va_ff[TRITS-1];
   assign cm_acc     = p2_acc_ff[TRITS-1];

   // Finish add and subtract, negate, and route the other results.
   always_comb begin
      cm_sum    = cm_va + cm_acc;
      cm_int_in = '0;
      case (cm_ctl_src.func) inside
         bta_pkg::FUNC_ADD, bta_pkg::FUNC_SUB: begin
            if (cm_sum > HALF_V) begin
               cm_val_in = cm_sum - MOD_V;
            end else if (cm_sum < -HALF_V) begin
               cm_val_in = cm_sum + MOD_V;
            end else begin
               cm_val_in = cm_sum;
            end
         end
         bta_pkg::FUNC_NEG:                     cm_val_in = -cm_va;
         bta_pkg::FUNC_MUL, bta_pkg::FUNC_FMUL: cm_val_in = cm_acc;
         bta_pkg::FUNC_FROM_INT:                cm_val_in = p2_ni_ff[TRITS-1];
         bta_pkg::FUNC_TO_INT: begin
            cm_val_in = '0;
            cm_int_in = INT_W'(cm_va);
         end
         default:                               cm_val_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         cm_ctl_ff <= cm_ctl_src;
      end
      if (adv) begin
         cm_val_ff <= cm_val_in;
         cm_int_ff <= cm_int_in;
      end
   end

   // ---------------- Phase 3: binary to canonical trits ----------------
   bta_pkg::ctl_type         cv_ctl;
   logic [TW-1:0]            cv_word;
   logic signed [INT_W-1:0]  cv_int;

   bta_conv #(
      .TRITS (TRITS),
      .VW    (VW)
   ) u_conv (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (cm_ctl_ff),
      .in_value (cm_val_ff),
      .in_int   (cm_int_ff),
      .out_ctl  (cv_ctl),
      .out_word (cv_word),
      .out_int  (cv_int)
   );

   // ---------------- Output register ----------------
   bta_pkg::ctl_type         out_ctl_ff;
   logic [WORD_W-1:0]        out_word_ff;
   logic signed [INT_W-1:0]  out_int_ff;
   logic [WORD_W-1:0]        out_word_in;
   logic [TW-1:0]            shifted_word;

   assign shifted_word = cv_word >> (2 * FRAC);

   // Fixed multiply drops the low FRAC trits; non-word operations give zero.
   always_comb begin
      case (cv_ctl.func) inside
         bta_pkg::FUNC_FMUL: out_word_in = WORD_W'(shifted_word);
         bta_pkg::FUNC_ADD, bta_pkg::FUNC_SUB, bta_pkg::FUNC_NEG,
         bta_pkg::FUNC_MUL, bta_pkg::FUNC_FROM_INT: out_word_in = WORD_W'(cv_word);
         default: out_word_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ctl_ff <= cv_ctl;
      end
      if (adv) begin
         out_word_ff <= out_word_in;
         out_int_ff  <= cv_int;
      end
   end

   assign rsp_valid       = out_ctl_ff.valid;
   assign rsp_result_word = out_word_ff;
   assign rsp_int_result  = out_int_ff;

   // ---------------- Assertions ----------------
   logic [WORD_W/2-1:0] spare_trits;

   always_comb begin
      for (int i = 0; i < WORD_W / 2; i++) begin
         spare_trits[i] = rsp_result_word[2*i] & rsp_result_word[2*i+1];
      end
   end

   // Every delivered word is canonical.
   a_canonical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> spare_trits == '0)
      else $error("result word holds a spare trit code");

   // Only the to-integer operation drives the integer result.
   a_int_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_ctl_ff.func != bta_pkg::FUNC_TO_INT |-> rsp_int_result == '0)
      else $error("integer result set for a word operation");

   // The to-integer operation gives a zero word.
   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_ctl_ff.func == bta_pkg::FUNC_TO_INT |-> rsp_result_word == '0)
      else $error("word result set for to-integer");

   // A held beat freezes the last conversion stage as well.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(cv_ctl) && $stable(cv_word))
      else $error("pipeline moved during a stall");

endmodule

FILE: test/alu_checker.sv
// Result checker for the balanced-ternary ALU: predicts every operation and compares the results.
`timescale 1ns / 100ps
module alu_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [bta_pkg::FUNC_W-1:0]        req_func,
   input  logic [bta_pkg::WORD_W-1:0]        req_operand_a,
   input  logic [bta_pkg::WORD_W-1:0]        req_operand_b,
   input  logic signed [bta_pkg::INT_W-1:0]  req_int_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [bta_pkg::WORD_W-1:0]        rsp_result_word,
   input  logic signed [bta_pkg::INT_W-1:0]  rsp_int_result,
   output int                                fail_count,
   output int                                pending_count
);

   localparam int NTRITS = bta_pkg::TRITS_DEF;
   localparam int NFRAC  = bta_pkg::FRAC_DEF;
   localparam int WORD_W = bta_pkg::WORD_W;
   localparam int INT_W  = bta_pkg::INT_W;
   localparam int FUNC_W = bta_pkg::FUNC_W;
   localparam longint MODULUS = longint'(bta_pkg::pow3(NTRITS));

   typedef struct packed {
      logic [WORD_W-1:0]       word;
      logic signed [INT_W-1:0] num;
   } answer_type;

   answer_type answers_due[$];

   // Signed value of the word's low trits, spare code counted as zero.
   function automatic longint word_value(input logic [WORD_W-1:0] w);
      longint acc;
      longint pw;
      acc = 0;
      pw = 1;
      for (int k = 0; k < NTRITS; k++) begin
         if (w[2*k +: 2] == bta_pkg::DIGIT_PLUS) acc += pw;
         else if (w[2*k +: 2] == bta_pkg::DIGIT_MINUS) acc -= pw;
         pw *= 3;
      end
      return acc;
   endfunction

   // Canonical word of a value, wrapped into the balanced range.
   function automatic logic [WORD_W-1:0] value_word(input longint v);
      logic [WORD_W-1:0] w;
      longint d;
      w = '0;
      for (int k = 0; k < NTRITS; k++) begin
         d = v % 3;
         if (d > 1) d -= 3;
         if (d < -1) d += 3;
         if (d == 1) w[2*k +: 2] = bta_pkg::DIGIT_PLUS;
         else if (d == -1) w[2*k +: 2] = bta_pkg::DIGIT_MINUS;
         v = (v - d) / 3;
      end
      return w;
   endfunction

   // Product modulo 3^20 computed without overflow by summing shifted partials.
   function automatic longint mul_mod(input longint a, input logic [WORD_W-1:0] b);
      longint acc;
      longint sh;
      acc = 0;
      sh = a % MODULUS;
      for (int k = 0; k < NTRITS; k++) begin
         if (b[2*k +: 2] == bta_pkg::DIGIT_PLUS) acc = (acc + sh) % MODULUS;
         else if (b[2*k +: 2] == bta_pkg::DIGIT_MINUS) acc = (acc - sh) % MODULUS;
         sh = (sh * 3) % MODULUS;
      end
      return acc;
   endfunction

   function automatic answer_type predict_answer(input logic [FUNC_W-1:0] f,
                                                 input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic signed [INT_W-1:0] iv);
      answer_type r;
      longint va;
      longint vb;
      r = '0;
      va = word_value(a);
      vb = word_value(b);
      case (f)
         bta_pkg::FUNC_ADD:      r.word = value_word(va + vb);
         bta_pkg::FUNC_SUB:      r.word = value_word(va - vb);
         bta_pkg::FUNC_NEG:      r.word = value_word(-va);
         bta_pkg::FUNC_MUL:      r.word = value_word(mul_mod(va, b));
         bta_pkg::FUNC_FMUL:     r.word = value_word(mul_mod(va, b)) >> (2 * NFRAC);
         bta_pkg::FUNC_TO_INT:   r.num = INT_W'(va);
         bta_pkg::FUNC_FROM_INT: r.word = value_word(longint'(iv));
         default:                r = '0;
      endcase
      return r;
   endfunction

   assign pending_count = answers_due.size();

   // Queue a prediction for each request beat and check each response beat.
   always @(posedge clock) begin
      answer_type exp_ans;
      int         errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            answers_due.push_back(predict_answer(req_func, req_operand_a,
                                                 req_operand_b, req_int_value));
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("response beat with no request outstanding");
               errs++;
            end else begin
               exp_ans = answers_due.pop_front();
               if (rsp_result_word !== exp_ans.word) begin
                  $error("result_word expected %h actual %h", exp_ans.word,
                         rsp_result_word);
                  errs++;
               end
               if (rsp_int_result !== exp_ans.num) begin
                  $error("int_result expected %0d actual %0d", exp_ans.num,
                         rsp_int_result);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

FILE: test/testbench.sv
// Top of the ALU testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps
module testbench;

   localparam int FUNC_W = bta_pkg::FUNC_W;
   localparam int WORD_W = bta_pkg::WORD_W;
   localparam int INT_W  = bta_pkg::INT_W;
   localparam int NTRITS = bta_pkg::TRITS_DEF;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [FUNC_W-1:0]       req_func = '0;
   logic [WORD_W-1:0]       req_operand_a = '0;
   logic [WORD_W-1:0]       req_operand_b = '0;
   logic signed [INT_W-1:0] req_int_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [WORD_W-1:0]       rsp_result_word;
   logic signed [INT_W-1:0] rsp_int_result;
   int                      fail_count;
   int                      pending_count;
   int                      beats_sent = 0;
   bit                      stimulus_done = 1'b0;

   localparam logic [WORD_W-1:0] ALL_POS = {NTRITS{bta_pkg::DIGIT_PLUS}};
   localparam logic [WORD_W-1:0] ALL_NEG = {NTRITS{bta_pkg::DIGIT_MINUS}};
   localparam logic [WORD_W-1:0] ALL_ONE = '1;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;
   localparam int INT_MAX = 1743392200;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   balanced_ternary_alu dut (.*);

   alu_checker checker_inst (.*);

   // Random word; mostly canonical codes, sometimes raw bits with spare codes.
   function automatic logic [WORD_W-1:0] random_word();
      logic [WORD_W-1:0] w;
      w = WORD_W'({$urandom, $urandom});
      if ($urandom_range(0, 3) != 0)
         for (int k = 0; k < NTRITS; k++)
            if (w[2*k +: 2] == 2'b11) w[2*k +: 2] = bta_pkg::DIGIT_ZERO;
      if ($urandom_range(0, 3) == 0) w = w & {WORD_W{1'b1}} >> (2 * $urandom_range(0, 19));
      return w;
   endfunction

   // Drive one request beat after a random gap and hold it until accepted.
   task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b, input logic signed [INT_W-1:0] iv);
      int gap;
      gap = $urandom_range(0, 4);
      if (beats_sent % 60 > 45) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_operand_a <= a;
      req_operand_b <= b;
      req_int_value <= iv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   // Response side drops ready for a random stall after each accepted beat.
   always @(posedge clock) begin
      int stall;
      if (!reset) begin
         if (rsp_ready && rsp_valid) begin
            stall = (beats_sent % 60 > 45) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [FUNC_W-1:0] f;
      int                iv;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: extremes, every operation, spare codes and the unused selector.
      send_beat(bta_pkg::FUNC_ADD, ALL_POS, ALL_POS, 0);
      send_beat(bta_pkg::FUNC_ADD, ALL_NEG, ALL_NEG, 0);
      send_beat(bta_pkg::FUNC_SUB, ALL_NEG, ALL_POS, 0);
      send_beat(bta_pkg::FUNC_SUB, '0, ALL_ONE, 0);
      send_beat(bta_pkg::FUNC_NEG, ALL_POS, '0, 0);
      send_beat(bta_pkg::FUNC_NEG, ALL_ONE, '0, 0);
      send_beat(bta_pkg::FUNC_MUL, ALL_POS, ALL_POS, 0);
      send_beat(bta_pkg::FUNC_MUL, ALL_NEG, ALL_POS, 0);
      send_beat(bta_pkg::FUNC_FMUL, ALL_POS, ALL_NEG, 0);
      send_beat(bta_pkg::FUNC_FMUL, ALL_ONE, ALL_ONE, 0);
      send_beat(bta_pkg::FUNC_TO_INT, ALL_POS, '0, 0);
      send_beat(bta_pkg::FUNC_TO_INT, ALL_NEG, '0, 0);
      send_beat(bta_pkg::FUNC_TO_INT, ALL_ONE, '0, 0);
      send_beat(bta_pkg::FUNC_FROM_INT, '0, '0, INT_MAX);
      send_beat(bta_pkg::FUNC_FROM_INT, '0, '0, -INT_MAX);
      send_beat(bta_pkg::FUNC_FROM_INT, '0, '0, 32'sh7FFFFFFF);
      send_beat(bta_pkg::FUNC_FROM_INT, '0, '0, 32'sh80000000);
      send_beat(bta_pkg::FUNC_FROM_INT, '0, '0, -1);
      send_beat(FUNC_SPARE, ALL_POS, ALL_NEG, -1);
      send_beat(bta_pkg::FUNC_ADD, ALL_ONE, ALL_ONE, -1);

      // Drain the pipeline once with the sender held off.
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      // Random beats over all selectors and operand patterns.
      repeat (450) begin
         f = FUNC_W'($urandom_range(0, 7));
         iv = $urandom;
         if ($urandom_range(0, 1) == 0) iv = $urandom_range(0, 2 * INT_MAX) - INT_MAX;
         send_beat(f, random_word(), random_word(), iv);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Verdict once all expected responses are back and the pipeline has settled.
   initial begin
      wait (stimulus_done);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d beats over all seven operations, the unused selector and spare codes,",
               beats_sent);
      $display("with random gaps and stalls on both channels.");
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Overall time limit.
   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

endmodule
